FILE: rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the terminal escape stripper
// Parse state codes, control byte codes and the decode result type.
// ----------------------------------------------------------------------------
package tes_pkg;

   localparam int unsigned ByteWidth = 8;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef enum logic [2:0] {
      ST_NORMAL  = 3'd0,
      ST_ESC     = 3'd1,
      ST_CSI     = 3'd2,
      ST_DCS     = 3'd3,
      ST_DCS_STR = 3'd4,
      ST_OSC     = 3'd5,
      ST_OSC_STR = 3'd6,
      ST_DROP    = 3'd7
   } parse_state_type;

   localparam byte_type CharBel   = 8'h07;
   localparam byte_type CharBs    = 8'h08;
   localparam byte_type CharCr    = 8'h0D;
   localparam byte_type CharCan   = 8'h18;
   localparam byte_type CharSub   = 8'h1A;
   localparam byte_type CharEsc   = 8'h1B;
   localparam byte_type CharSpace = 8'h20;
   localparam byte_type CharHash  = 8'h23;
   localparam byte_type CharLparen = 8'h28;
   localparam byte_type CharRparen = 8'h29;
   localparam byte_type CharStar  = 8'h2A;
   localparam byte_type CharPlus  = 8'h2B;
   localparam byte_type FinalLo   = 8'h40;
   localparam byte_type FoldHi    = 8'h5F;
   localparam byte_type FinalHi   = 8'h7E;
   localparam byte_type CtrlMask  = 8'h6F;
   localparam byte_type C1Dcs     = 8'h90;
   localparam byte_type C1Csi     = 8'h9B;
   localparam byte_type C1Osc     = 8'h9D;
   localparam byte_type C1Pm      = 8'h9E;
   localparam byte_type C1Apc     = 8'h9F;

   typedef struct packed {
      parse_state_type next_state;
      logic            keep;
      byte_type        out_byte;
   } decode_type;

endpackage

FILE: rtl/core/tes_if.sv
// ----------------------------------------------------------------------------
// tes_if: byte channels of the terminal escape stripper
// Valid/ready channels for raw input words and for kept output words.
// ----------------------------------------------------------------------------
interface tes_req_if;
   logic                     valid;
   logic                     ready;
   logic [tes_pkg::ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface tes_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [tes_pkg::ByteWidth-1:0] clean_byte;

   modport source (output valid, output clean_byte, input ready);
   modport sink (input valid, input clean_byte, output ready);
endinterface

FILE: rtl/core/tes_decode.sv
// ----------------------------------------------------------------------------
// tes_decode: per-byte escape parser step
// Computes the next parse state and whether the byte is kept.
// ----------------------------------------------------------------------------
module tes_decode (
   input  tes_pkg::parse_state_type state,
   input  tes_pkg::byte_type        in_byte,
   output tes_pkg::decode_type      result
);
   import tes_pkg::*;

   parse_state_type s;
   byte_type        b;
   logic            is_ctrl;
   logic            is_passed;
   logic            final_byte;
   logic            esc_inter;

   always_comb begin
      s = state;
      b = in_byte;
      // fold ESC 0x40..0x5F into its C1 code
      if (state == ST_ESC && in_byte >= FinalLo && in_byte <= FoldHi) begin
         s = ST_NORMAL;
         b = {3'b100, in_byte[4:0]};
      end
   end

   assign is_ctrl    = (b & CtrlMask) < CharSpace;
   assign is_passed  = b >= CharBs && b <= CharCr;
   assign final_byte = b >= FinalLo && b <= FinalHi;
   assign esc_inter  = b == CharHash || b == CharSpace || b == CharLparen ||
                       b == CharRparen || b == CharStar || b == CharPlus;

   always_comb begin
      result.next_state = s;
      result.keep       = 1'b0;
      result.out_byte   = b;
      priority if (state == ST_DROP) begin
         result.next_state = ST_NORMAL;
      end else if (b == CharCan || b == CharSub) begin
         result.next_state = ST_NORMAL;
      end else if (b == CharEsc) begin
         result.next_state = ST_ESC;
      end else if (b == C1Csi) begin
         result.next_state = ST_CSI;
      end else if (b == C1Dcs || b == C1Pm || b == C1Apc) begin
         result.next_state = ST_DCS;
      end else if (b == C1Osc) begin
         result.next_state = ST_OSC;
      end else if (is_ctrl) begin
         if (b == CharBel) begin
            if (s == ST_OSC_STR) begin
               result.next_state = ST_NORMAL;
            end else begin
               result.keep = 1'b1;
            end
         end else begin
            result.keep = is_passed;
         end
      end else begin
         unique case (s)
            ST_NORMAL: result.keep = 1'b1;
            ST_ESC:    result.next_state = esc_inter ? ST_DROP : ST_NORMAL;
            ST_CSI:    if (final_byte) result.next_state = ST_NORMAL;
            ST_DCS:    if (final_byte) result.next_state = ST_DCS_STR;
            ST_OSC:    if (final_byte) result.next_state = ST_OSC_STR;
            default:   result.next_state = s;
         endcase
      end
   end

endmodule

FILE: rtl/core/terminal_escape_stripper.sv
// ----------------------------------------------------------------------------
// terminal_escape_stripper: removes ANSI/VT escape sequences from a byte stream
// Input register, one-step parser against the parse state, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries raw terminal output words (in_byte), one per handshake.
//   rsp carries the kept words (clean_byte); dropped words produce nothing,
//   so rsp gives zero or one word for each req word, in order.
//   Path: the req handshake loads the input register; the decode step then
//   moves a kept word into the result register once that register is free.
//   Throughput: one word per cycle while rsp does not stall; the parse state
//   is updated by a single decode step per word, which sets the rate.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to normal text.
//   When rsp stalls, the result register holds its word and the input
//   register still fills; req.ready drops only when both hold a word.
// ----------------------------------------------------------------------------
module terminal_escape_stripper (
   input logic clock,
   input logic reset,
   tes_req_if.sink   req,
   tes_rsp_if.source rsp
);
   import tes_pkg::*;

   logic            in_valid_ff, in_valid_in;
   byte_type        in_byte_ff, in_byte_in;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   byte_type        out_byte_ff, out_byte_in;
   decode_type      dec;
   logic            out_free;
   logic            consume;

   tes_decode u_decode (
      .state   (state_ff),
      .in_byte (in_byte_ff),
      .result  (dec)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign consume   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      if (out_free) begin
         out_valid_in = consume && dec.keep;
         if (consume && dec.keep) out_byte_in = dec.out_byte;
      end
      if (consume) begin
         state_in = dec.next_state;
      end
      if (req.ready) begin
         in_valid_in = req.valid;
         if (req.valid) in_byte_in = req.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ST_NORMAL;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.clean_byte = out_byte_ff;

endmodule

FILE: bench/tb_terminal_escape_stripper.sv
// ----------------------------------------------------------------------------
// tb_terminal_escape_stripper: self-checking bench for the escape stripper
// Drives raw terminal words with bursty timing while the result side stalls
// on its own pattern. A software copy of the escape parser predicts which
// words survive. Each kept word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_terminal_escape_stripper;
   import tes_pkg::*;

   localparam int unsigned RandomWords   = 550;
   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned WatchdogLimit = 1000;

   // byte codes, ranges and the C1 offset that have no package constant
   localparam byte_type C1Offset = 8'h40;
   localparam byte_type C1St     = 8'h9C;
   localparam byte_type CharNul  = 8'h00;
   localparam byte_type CharLf   = 8'h0A;
   localparam byte_type CharDel  = 8'h7F;
   localparam byte_type ParamLo  = 8'h20;
   localparam byte_type ParamHi  = 8'h3F;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_EVERY_THIRD,
      RX_LONG_STALL
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   tes_req_if req_ch ();
   tes_rsp_if rsp_ch ();

   terminal_escape_stripper u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   parse_state_type strip_state;
   byte_type        kept_bytes_q[$];
   byte_type        expected_byte;
   int unsigned     mismatch_count = 0;
   int unsigned     words_sent = 0;
   int unsigned     burst_left = 0;
   int unsigned     idle_cycles = 0;
   rx_mode_type     rx_mode = RX_ALWAYS;
   int unsigned     rx_phase = 0;

   // Advance the parser by one word; return 1 when the word is kept.
   function automatic logic strip_byte(input byte_type raw, output byte_type kept);
      byte_type        b;
      parse_state_type s;
      logic            keep;
      logic            is_final;
      b    = raw;
      s    = strip_state;
      keep = 1'b0;
      kept = raw;
      if (s == ST_DROP) begin
         strip_state = ST_NORMAL;
         return 1'b0;
      end
      // fold ESC + 0x40..0x5F into its C1 code
      if (s == ST_ESC && b >= FinalLo && b <= FoldHi) begin
         s = ST_NORMAL;
         b = b + C1Offset;
      end
      if (b == CharCan || b == CharSub) begin
         s = ST_NORMAL;
      end else if (b == CharEsc) begin
         s = ST_ESC;
      end else if (b == C1Csi) begin
         s = ST_CSI;
      end else if (b == C1Dcs || b == C1Pm || b == C1Apc) begin
         s = ST_DCS;
      end else if (b == C1Osc) begin
         s = ST_OSC;
      end else if ((b & CtrlMask) < CharSpace) begin
         if (b == CharBel) begin
            if (s == ST_OSC_STR) s = ST_NORMAL;
            else keep = 1'b1;
         end else if (b >= CharBs && b <= CharCr) begin
            keep = 1'b1;
         end
      end else begin
         is_final = (b >= FinalLo && b <= FinalHi);
         case (s)
            ST_NORMAL: keep = 1'b1;
            ST_ESC: begin
               if (b == CharHash || b == CharSpace || b == CharLparen ||
                   b == CharRparen || b == CharStar || b == CharPlus)
                  s = ST_DROP;
               else
                  s = ST_NORMAL;
            end
            ST_CSI: if (is_final) s = ST_NORMAL;
            ST_DCS: if (is_final) s = ST_DCS_STR;
            ST_OSC: if (is_final) s = ST_OSC_STR;
            default: ;
         endcase
      end
      strip_state = s;
      kept = b;
      return keep;
   endfunction

   function automatic byte_type text_byte();
      if ($urandom_range(0, 3) == 0) return byte_type'($urandom_range(8'hA0, 8'hFF));
      return byte_type'($urandom_range(8'h20, 8'h7F));
   endfunction

   // Sequence body word: mostly from the given range, now and then a
   // control that passes through even inside a sequence.
   function automatic byte_type body_byte(input byte_type lo, input byte_type hi);
      case ($urandom_range(0, 9))
         0: return byte_type'($urandom_range(CharBs, CharCr));
         1: return CharBel;
         default: return byte_type'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic send_word(input byte_type value);
      byte_type    kept;
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      words_sent++;
      if (strip_byte(value, kept)) kept_bytes_q.push_back(kept);
   endtask

   // Send a C1 introducer either as the 8-bit code or as ESC + 7-bit form.
   task automatic send_intro(input byte_type c1_code);
      if ($urandom_range(0, 1) == 0) begin
         send_word(c1_code);
      end else begin
         send_word(CharEsc);
         send_word(c1_code - C1Offset);
      end
   endtask

   task automatic test_plain_text();
      send_word(CharSpace);
      send_word(8'hFF);
      send_word(CharDel);
      send_word(CharNul);
      send_word(CharLf);
      send_word(CharBel);
   endtask

   task automatic test_escape_sequences();
      // ESC [ m: folded CSI with its final byte
      send_word(CharEsc);
      send_word(C1Csi - C1Offset);
      send_word(8'h6D);
      // ESC # swallows the next word, even a zero
      send_word(CharEsc);
      send_word(CharHash);
      send_word(CharNul);
      // ESC c: unfolded byte returns to normal text and is dropped
      send_word(CharEsc);
      send_word(8'h63);
   endtask

   task automatic test_c1_sequences();
      // OSC string ended by BEL
      send_word(C1Osc);
      send_word(8'h41);
      send_word(CharBel);
      // PM string ended by ESC backslash
      send_word(C1Pm);
      send_word(8'h71);
      send_word(CharEsc);
      send_word(C1St - C1Offset);
      // CR passes inside CSI, SUB aborts, then text resumes
      send_word(C1Csi);
      send_word(CharCr);
      send_word(CharSub);
      send_word(8'h41);
   endtask

   task automatic test_random_stream();
      int unsigned stop_at;
      stop_at = words_sent + RandomWords;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 6)) send_word(text_byte());
            3: begin
               send_intro(C1Csi);
               repeat ($urandom_range(0, 4)) send_word(body_byte(ParamLo, ParamHi));
               send_word(byte_type'($urandom_range(FinalLo, FinalHi)));
            end
            4: begin
               send_intro(C1Osc);
               repeat ($urandom_range(0, 2)) send_word(body_byte(ParamLo, ParamHi));
               send_word(byte_type'($urandom_range(FinalLo, FinalHi)));
               repeat ($urandom_range(0, 4)) send_word(text_byte());
               if ($urandom_range(0, 1) == 0) begin
                  send_word(CharBel);
               end else begin
                  send_word(CharEsc);
                  send_word(C1St - C1Offset);
               end
            end
            5: begin
               case ($urandom_range(0, 2))
                  0: send_intro(C1Dcs);
                  1: send_intro(C1Pm);
                  default: send_intro(C1Apc);
               endcase
               repeat ($urandom_range(0, 3)) send_word(body_byte(ParamLo, ParamHi));
               send_word(byte_type'($urandom_range(FinalLo, FinalHi)));
               repeat ($urandom_range(0, 4)) send_word(body_byte(8'h20, 8'hFF));
               send_word(CharEsc);
               send_word(C1St - C1Offset);
            end
            6: begin
               send_word(CharEsc);
               case ($urandom_range(0, 5))
                  0: send_word(CharHash);
                  1: send_word(CharSpace);
                  2: send_word(CharLparen);
                  3: send_word(CharRparen);
                  4: send_word(CharStar);
                  default: send_word(CharPlus);
               endcase
               send_word(byte_type'($urandom_range(0, 255)));
            end
            7: begin
               send_word(CharEsc);
               send_word(byte_type'($urandom_range(0, 255)));
            end
            8: begin
               case ($urandom_range(0, 2))
                  0: send_word(($urandom_range(0, 1) == 0) ? CharCan : CharSub);
                  1: send_word(byte_type'($urandom_range(0, 8'h1F)));
                  default: send_word(byte_type'($urandom_range(8'h80, 8'h9F)));
               endcase
            end
            default: repeat ($urandom_range(1, 4)) send_word(byte_type'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // Result side stall pattern: switch to a random mode whenever the phase count runs out.
   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_mode  = rx_mode_type'($urandom_range(0, 3));
         rx_phase = $urandom_range(16, 64);
      end
      rx_phase--;
      case (rx_mode)
         RX_ALWAYS:      rsp_ch.ready <= 1'b1;
         RX_RANDOM:      rsp_ch.ready <= 1'($urandom_range(0, 1));
         RX_EVERY_THIRD: rsp_ch.ready <= (rx_phase % 3) != 0;
         default:        rsp_ch.ready <= (rx_phase % 16) >= 12;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (kept_bytes_q.size() == 0) begin
            $error("clean_byte: no word expected, actual %h", rsp_ch.clean_byte);
            mismatch_count++;
         end else begin
            expected_byte = kept_bytes_q.pop_front();
            if (rsp_ch.clean_byte !== expected_byte) begin
               $error("clean_byte: expected %h, actual %h", expected_byte,
                      rsp_ch.clean_byte);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = CharNul;
      strip_state    = ST_NORMAL;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_text();
      test_escape_sequences();
      test_c1_sequences();
      test_random_stream();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (kept_bytes_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tes_pkg.sv
rtl/core/tes_if.sv
rtl/core/tes_decode.sv
rtl/core/terminal_escape_stripper.sv
bench/tb_terminal_escape_stripper.sv
